### sv/assert_macros.svh
// Assertion macros for the touch gesture classifier RTL.
// Concurrent forms for simulation; empty bodies when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication, disabled while reset is asserted (active low).
`define TGC_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tgc assertion failed");

// Next-cycle implication, disabled while reset is asserted (active low).
`define TGC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tgc assertion failed");

`else

`define TGC_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define TGC_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

### sv/tgc_pkg.sv
// Package for the touch gesture classifier: field widths, codes, register
// indexes and reset values. No dependencies.
`default_nettype none

package tgc_pkg;

    localparam int unsigned CMD_W    = 2;
    localparam int unsigned ZONE_W   = 2;
    localparam int unsigned POS_W    = 11;
    localparam int unsigned TIME_W   = 32;
    localparam int unsigned GEST_W   = 4;
    localparam int unsigned THR_W    = 10;
    localparam int unsigned MS_W     = 16;
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 16;

    typedef enum logic [CMD_W-1:0] {
        CMD_PRESS   = 2'd0,
        CMD_MOVE    = 2'd1,
        CMD_RELEASE = 2'd2
    } cmd_t;

    typedef enum logic [ZONE_W-1:0] {
        ZONE_SCREEN    = 2'd0,
        ZONE_BUTTON    = 2'd1,
        ZONE_ELSEWHERE = 2'd2
    } zone_t;

    typedef enum logic [GEST_W-1:0] {
        G_NONE   = 4'd0,
        G_TAP    = 4'd1,
        G_DOUBLE = 4'd2,
        G_LONG   = 4'd3,
        G_LEFT   = 4'd4,
        G_RIGHT  = 4'd5,
        G_UP     = 4'd6,
        G_DOWN   = 4'd7,
        G_BUTTON = 4'd8
    } gesture_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SWIPE_THRESHOLD = 2'd0,
        REG_LONG_TAP        = 2'd1,
        REG_DOUBLE_TAP      = 2'd2
    } cfg_reg_t;

    localparam logic [THR_W-1:0] SWIPE_THRESHOLD_RST = THR_W'(72);
    localparam logic [MS_W-1:0]  LONG_TAP_RST        = MS_W'(800);
    localparam logic [MS_W-1:0]  DOUBLE_TAP_RST      = MS_W'(200);

endpackage

`default_nettype wire

### sv/touch_gesture_classifier_core.sv
// Touch gesture classifier: event input register, combinational classify and
// state update, result output register. Depends on tgc_pkg, assert_macros.svh.
//
//  channel | ports                              | direction
//  --------+------------------------------------+----------
//  event   | s_valid/s_ready, s_command..s_time | in
//  result  | m_valid/m_ready, m_gesture..m_held | out
//  config  | cfg_valid/cfg_ready, cfg_index/data| in
//
// One event per cycle while results are accepted; each event passes the input
// register, then classification into the result register, which also updates
// the contact state. A stalled result holds the pipeline; the input register
// still takes a transfer while the result register is free or draining.
// aresetn (sync, low) clears valids, contact state and loads register defaults.
`default_nettype none

module touch_gesture_classifier_core (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,

    input  wire logic                              s_valid,
    output logic                                   s_ready,
    input  wire logic [tgc_pkg::CMD_W-1:0]         s_command,
    input  wire logic [tgc_pkg::ZONE_W-1:0]        s_zone,
    input  wire logic signed [tgc_pkg::POS_W-1:0]  s_pos_x,
    input  wire logic signed [tgc_pkg::POS_W-1:0]  s_pos_y,
    input  wire logic [tgc_pkg::TIME_W-1:0]        s_time_ms,

    output logic                                   m_valid,
    input  wire logic                              m_ready,
    output logic [tgc_pkg::GEST_W-1:0]             m_gesture,
    output logic                                   m_touch_held,
    output logic signed [tgc_pkg::POS_W-1:0]       m_held_x,
    output logic signed [tgc_pkg::POS_W-1:0]       m_held_y,

    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [tgc_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [tgc_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import tgc_pkg::*;

    `include "assert_macros.svh"

    // config registers
    logic [THR_W-1:0] thr_reg;
    logic [MS_W-1:0]  long_ms_reg;
    logic [MS_W-1:0]  dbl_ms_reg;

    // input register
    logic                    in_valid_reg;
    logic [CMD_W-1:0]        in_cmd_reg;
    logic [ZONE_W-1:0]       in_zone_reg;
    logic signed [POS_W-1:0] in_x_reg;
    logic signed [POS_W-1:0] in_y_reg;
    logic [TIME_W-1:0]       in_time_reg;

    // contact state
    logic                    contact_reg, contact_next;
    logic signed [POS_W-1:0] start_x_reg, start_x_next;
    logic signed [POS_W-1:0] start_y_reg, start_y_next;
    logic [TIME_W-1:0]       start_t_reg, start_t_next;
    logic                    tap_valid_reg, tap_valid_next;
    logic [TIME_W-1:0]       tap_t_reg, tap_t_next;

    // result register
    logic                    out_valid_reg;
    gesture_t                out_gest_reg;
    logic                    out_held_reg;
    logic signed [POS_W-1:0] out_x_reg;
    logic signed [POS_W-1:0] out_y_reg;

    logic                    advance;
    gesture_t                swipe_gest;
    gesture_t                gest_next;
    logic signed [POS_W:0]   dx;
    logic signed [POS_W:0]   dy;
    logic signed [POS_W:0]   thr_pos;
    logic signed [POS_W:0]   thr_neg;
    logic [TIME_W-1:0]       hold_ms;
    logic [TIME_W-1:0]       gap_ms;

    assign advance   = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready   = !in_valid_reg || advance;
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thr_reg     <= SWIPE_THRESHOLD_RST;
            long_ms_reg <= LONG_TAP_RST;
            dbl_ms_reg  <= DOUBLE_TAP_RST;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                REG_SWIPE_THRESHOLD: thr_reg     <= cfg_data[THR_W-1:0];
                REG_LONG_TAP:        long_ms_reg <= cfg_data[MS_W-1:0];
                REG_DOUBLE_TAP:      dbl_ms_reg  <= cfg_data[MS_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_cmd_reg  <= s_command;
            in_zone_reg <= s_zone;
            in_x_reg    <= s_pos_x;
            in_y_reg    <= s_pos_y;
            in_time_reg <= s_time_ms;
        end
    end

    // swipe test: horizontal first, strict compare against threshold
    always_comb begin
        dx      = (POS_W+1)'(in_x_reg) - (POS_W+1)'(start_x_reg);
        dy      = (POS_W+1)'(in_y_reg) - (POS_W+1)'(start_y_reg);
        thr_pos = $signed({{(POS_W+1-THR_W){1'b0}}, thr_reg});
        thr_neg = -thr_pos;
        priority if (dx > thr_pos) begin
            swipe_gest = G_RIGHT;
        end else if (dx < thr_neg) begin
            swipe_gest = G_LEFT;
        end else if (dy > thr_pos) begin
            swipe_gest = G_DOWN;
        end else if (dy < thr_neg) begin
            swipe_gest = G_UP;
        end else begin
            swipe_gest = G_NONE;
        end
    end

    assign hold_ms = in_time_reg - start_t_reg;
    assign gap_ms  = in_time_reg - tap_t_reg;

    always_comb begin
        gest_next      = G_NONE;
        contact_next   = contact_reg;
        start_x_next   = start_x_reg;
        start_y_next   = start_y_reg;
        start_t_next   = start_t_reg;
        tap_valid_next = tap_valid_reg;
        tap_t_next     = tap_t_reg;
        unique case (in_cmd_reg)
            CMD_PRESS: begin
                if (in_zone_reg == ZONE_SCREEN) begin
                    contact_next = 1'b1;
                    start_x_next = in_x_reg;
                    start_y_next = in_y_reg;
                    start_t_next = in_time_reg;
                end else if (in_zone_reg == ZONE_BUTTON) begin
                    gest_next = G_BUTTON;
                end
            end
            CMD_MOVE: begin
                if (contact_reg && in_zone_reg != ZONE_SCREEN) begin
                    contact_next = 1'b0;
                    gest_next    = swipe_gest;
                end
            end
            CMD_RELEASE: begin
                if (contact_reg) begin
                    contact_next = 1'b0;
                    priority if (swipe_gest != G_NONE) begin
                        gest_next      = swipe_gest;
                        tap_valid_next = 1'b0;
                    end else if (hold_ms >= TIME_W'(long_ms_reg)) begin
                        gest_next      = G_LONG;
                        tap_valid_next = 1'b0;
                    end else if (tap_valid_reg && gap_ms <= TIME_W'(dbl_ms_reg)) begin
                        gest_next      = G_DOUBLE;
                        tap_valid_next = 1'b0;
                    end else begin
                        gest_next      = G_TAP;
                        tap_valid_next = 1'b1;
                        tap_t_next     = in_time_reg;
                    end
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            contact_reg   <= 1'b0;
            start_x_reg   <= '0;
            start_y_reg   <= '0;
            start_t_reg   <= '0;
            tap_valid_reg <= 1'b0;
            tap_t_reg     <= '0;
        end else if (advance) begin
            contact_reg   <= contact_next;
            start_x_reg   <= start_x_next;
            start_y_reg   <= start_y_next;
            start_t_reg   <= start_t_next;
            tap_valid_reg <= tap_valid_next;
            tap_t_reg     <= tap_t_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_gest_reg <= gest_next;
            out_held_reg <= contact_next;
            out_x_reg    <= contact_next ? start_x_next : '0;
            out_y_reg    <= contact_next ? start_y_next : '0;
        end
    end

    assign m_valid      = out_valid_reg;
    assign m_gesture    = out_gest_reg;
    assign m_touch_held = out_held_reg;
    assign m_held_x     = out_x_reg;
    assign m_held_y     = out_y_reg;

    `TGC_ASSERT_IMPL(a_released_pos_zero, aclk, aresetn,
        m_valid && !m_touch_held, m_held_x == '0 && m_held_y == '0)
    `TGC_ASSERT_IMPL(a_stall_only_when_full, aclk, aresetn,
        !s_ready, in_valid_reg && out_valid_reg && !m_ready)
    `TGC_ASSERT_NEXT(a_transfer_lands, aclk, aresetn,
        s_valid && s_ready, in_valid_reg)
    `TGC_ASSERT_NEXT(a_button_keeps_contact, aclk, aresetn,
        advance && in_cmd_reg == CMD_PRESS && in_zone_reg == ZONE_BUTTON,
        contact_reg == $past(contact_reg) && m_gesture == G_BUTTON)

endmodule

`default_nettype wire
